// ===== rtl/tcw_pkg.sv =====
// shared types and constants for the text console writer
package tcw_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // character codes
    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;

    // cell value after reset: grey space on black
    localparam logic [15:0] RESET_CELL   = 16'h0720;

    // configuration register indexes and reset values
    localparam logic       REG_FOREGROUND = 1'b0;
    localparam logic       REG_BACKGROUND = 1'b1;
    localparam logic [3:0] FG_RESET       = 4'd7;
    localparam logic [3:0] BG_RESET       = 4'd0;

    // command codes
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    // controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SCROLL,
        ST_DRAIN
    } state_t;

endpackage

// ===== rtl/text_console_writer.sv =====
// text console writer: screen cell memory, cursor and command sequencer
//
//  channel   signals                                   handshake
//  --------  ----------------------------------------  -------------------------
//  command   cmd, char_code, read_row, read_col        start high, busy low
//  result    cell_value, cursor_row, cursor_col,       done high for one cycle
//            scrolled
//  config    cfg_write, cfg_index, cfg_data            cfg_write high, no wait
//
// put, newline and the unused code give done in the cycle after the beat, unless a
// line feed scrolls; a read passes the registered read port of the cell memory and
// the ST_READ state. clear sweeps every cell one cell a cycle. a scroll moves each
// row below the top up a row, one cell a cycle through the read and write ports.
// after reset a clearing pass over every cell holds busy high.
// results cannot be stalled; a new command may be taken in the done cycle.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  char_code,
    input  logic [4:0]  read_row,
    input  logic [6:0]  read_col,
    output logic        done,
    output logic [15:0] cell_value,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic        scrolled,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0] SCROLL_LAST = AW'((ROWS - 1) * COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
    localparam logic [CW:0]   COLS_C      = (CW + 1)'(COLUMNS);

    // cell memory
    logic [15:0] mem [CELLS];
    logic [15:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [3:0]    fg_reg, fg_next;
    logic [3:0]    bg_reg, bg_next;
    logic          done_reg, done_next;
    logic [15:0]   value_reg, value_next;
    logic          scrolled_reg, scrolled_next;
    logic          wr_pend_reg, wr_pend_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic          in_range_reg, in_range_next;

    logic          accept;
    logic [AW-1:0] put_addr;
    logic [AW-1:0] rd_addr;
    logic [CW:0]   col_inc;
    logic [7:0]    attr;

    assign accept   = start && (state_reg == ST_IDLE);
    assign attr     = {bg_reg, fg_reg};
    assign put_addr = AW'(row_reg) * COLS_A + AW'(col_reg);
    assign rd_addr  = AW'(read_row) * COLS_A + AW'(read_col);
    assign col_inc  = {1'b0, col_reg} + 1'b1;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            cnt_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            fg_reg       <= FG_RESET;
            bg_reg       <= BG_RESET;
            done_reg     <= 1'b0;
            scrolled_reg <= 1'b0;
            wr_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            fg_reg       <= fg_next;
            bg_reg       <= bg_next;
            done_reg     <= done_next;
            scrolled_reg <= scrolled_next;
            wr_pend_reg  <= wr_pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        wr_addr_reg  <= wr_addr_next;
        in_range_reg <= in_range_next;
    end

    // configuration writes
    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FOREGROUND: fg_next = cfg_data;
                REG_BACKGROUND: bg_next = cfg_data;
                default:        fg_next = fg_reg;
            endcase
        end
    end

    // sequencer: next state, memory port control, result
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        done_next     = 1'b0;
        value_next    = 16'h0000;
        scrolled_next = 1'b0;
        wr_pend_next  = 1'b0;
        wr_addr_next  = cnt_reg;
        in_range_next = in_range_reg;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = RESET_CELL;
        mem_raddr     = rd_addr;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_PUT:
                        begin
                            done_next = 1'b1;
                            if (char_code != NEWLINE_CODE)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = put_addr;
                                mem_wdata = {attr, char_code};
                                col_next  = col_inc[CW-1:0];
                            end
                            // line feed: explicit newline or wrap at last column
                            if (char_code == NEWLINE_CODE || col_inc >= COLS_C)
                            begin
                                col_next = '0;
                                if (row_reg >= LAST_ROW)
                                begin
                                    row_next   = LAST_ROW;
                                    done_next  = 1'b0;
                                    cnt_next   = '0;
                                    state_next = ST_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            in_range_next = ({2'b00, read_row} < 7'(ROWS)) &&
                                            ({1'b0, read_col} < 8'(COLUMNS));
                            state_next    = ST_READ;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                done_next  = 1'b1;
                value_next = in_range_reg ? rdata_reg : 16'h0000;
                state_next = ST_IDLE;
            end

            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {attr, SPACE_CODE};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // read one row ahead, write the beat read last cycle
            ST_SCROLL:
            begin
                mem_raddr    = cnt_reg + COLS_A;
                wr_pend_next = 1'b1;
                wr_addr_next = cnt_reg;
                mem_we       = wr_pend_reg;
                mem_waddr    = wr_addr_reg;
                mem_wdata    = rdata_reg;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == SCROLL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                mem_we        = wr_pend_reg;
                mem_waddr     = wr_addr_reg;
                mem_wdata     = rdata_reg;
                done_next     = 1'b1;
                scrolled_next = 1'b1;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign cell_value = value_reg;
    assign scrolled   = scrolled_reg;
    assign cursor_row = 5'(row_reg);
    assign cursor_col = 7'(col_reg);

endmodule

// ===== rtl/tcw_checker.sv =====
// port-level checks for the text console writer
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  cmd,
    input logic        done,
    input logic [15:0] cell_value,
    input logic [4:0]  cursor_row,
    input logic [6:0]  cursor_col,
    input logic        scrolled
);

    // every result follows an accepted beat or a busy period
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a command");

    // non-read commands either finish next cycle with zero cell value or go busy
    a_nonread_value: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd != 2'(CMD_READ)) |=> ((done && cell_value == 16'h0000) || busy))
        else $error("non-read command gave a cell value");

    // a read is busy after its beat and then finishes with done high, busy low and no scroll flag
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == 2'(CMD_READ)) |=> busy ##1 (done && !busy && !scrolled))
        else $error("read result out of place");

    // a scroll leaves the cursor at the start of the last row
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        scrolled |-> (done && cursor_col == 7'd0 && cursor_row == 5'(ROWS - 1)))
        else $error("scroll with wrong cursor");

    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(cursor_col) < COLUMNS && 32'(cursor_row) < ROWS))
        else $error("cursor off screen");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .cell_value (cell_value),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .scrolled   (scrolled)
);

// ===== tb/tb_text_console_writer.sv =====
// self-checking testbench for the text console writer: shadow screen, command driver, result monitor
module tb_text_console_writer
    import tcw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS = DEF_COLUMNS;
    localparam int ROWS    = DEF_ROWS;
    localparam int CELLS   = ROWS * COLUMNS;

    // code left unused by the block, must change nothing
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // items per random phase
    localparam int PHASE_ITEMS = 195;
    // every beat a full scroll or clear plus sender gaps, several times over
    localparam longint CYCLE_LIMIT = 8_000_000;
    // quiet cycles after the last result
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } console_cmd_t;

    typedef struct packed {
        logic [15:0] cell_val;
        logic [4:0]  crow;
        logic [6:0]  ccol;
        logic        scroll;
    } console_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = CMD_PUT;
    logic [7:0]  char_code = 8'h00;
    logic [4:0]  read_row = 5'd0;
    logic [6:0]  read_col = 7'd0;
    logic        done;
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
    logic        cfg_write = 1'b0;
    logic        cfg_index = REG_FOREGROUND;
    logic [3:0]  cfg_data = 4'd0;

    // shadow of the screen, cursor and colors
    logic [15:0] shadow_screen [CELLS];
    int          shadow_row;
    int          shadow_col;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;

    console_cmd_t    pending_commands [$];
    console_result_t expected_results [$];
    console_cmd_t    presented_cmd;
    int              sender_idle_pct = 0;
    int              mismatch_count = 0;
    longint          cycle_count = 0;
    int              result_count = 0;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .done       (done),
        .cell_value (cell_value),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    // move to column 0 of the next row, scrolling up when already on the last row
    function automatic bit advance_line();
        int i;
        shadow_col = 0;
        if (shadow_row >= ROWS - 1)
        begin
            for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
                shadow_screen[i] = shadow_screen[i + COLUMNS];
            shadow_row = ROWS - 1;
            return 1'b1;
        end
        shadow_row++;
        return 1'b0;
    endfunction

    // update the shadow screen with one command and return the result it must give
    function automatic console_result_t apply_command(input console_cmd_t c);
        console_result_t r;
        int              i;
        r = '0;
        case (c.op)
            CMD_PUT:
            begin
                if (c.ch == NEWLINE_CODE)
                    r.scroll = advance_line();
                else
                begin
                    shadow_screen[shadow_row * COLUMNS + shadow_col] = {bg_color, fg_color, c.ch};
                    shadow_col++;
                    if (shadow_col >= COLUMNS)
                        r.scroll = advance_line();
                end
            end
            CMD_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    shadow_screen[i] = {bg_color, fg_color, SPACE_CODE};
            end
            CMD_READ:
            begin
                if (int'(c.row) < ROWS && int'(c.col) < COLUMNS)
                    r.cell_val = shadow_screen[int'(c.row) * COLUMNS + int'(c.col)];
            end
            default:
            begin
            end
        endcase
        r.crow = shadow_row[4:0];
        r.ccol = shadow_col[6:0];
        return r;
    endfunction

    // command driver: holds start until the beat is taken, then maybe idles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(apply_command(presented_cmd));
            end
            if (!start || !busy)
            begin
                if (pending_commands.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    presented_cmd = pending_commands.pop_front();
                    start     <= 1'b1;
                    cmd       <= presented_cmd.op;
                    char_code <= presented_cmd.ch;
                    read_row  <= presented_cmd.row;
                    read_col  <= presented_cmd.col;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] result %0d %s: expected 0x%0h, got 0x%0h",
                     $realtime, result_count, what, want, got);
    endtask

    // result monitor: every done beat against the oldest expectation
    always @(posedge clk)
    begin
        console_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, cursor", 0, {cursor_row, cursor_col});
            else
            begin
                want = expected_results.pop_front();
                if (cell_value !== want.cell_val)
                    report_mismatch("cell_value", want.cell_val, cell_value);
                if (cursor_row !== want.crow)
                    report_mismatch("cursor_row", want.crow, cursor_row);
                if (cursor_col !== want.ccol)
                    report_mismatch("cursor_col", want.ccol, cursor_col);
                if (scrolled !== want.scroll)
                    report_mismatch("scrolled", want.scroll, scrolled);
            end
            result_count++;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("text_console_writer regression: fail");
            $finish;
        end
    end

    task automatic add_cmd(input logic [1:0] op, input logic [7:0] ch,
                           input logic [4:0] row, input logic [6:0] col);
        pending_commands.push_back('{op: op, ch: ch, row: row, col: col});
    endtask

    // wait until every beat is taken and answered and the block is idle
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (pending_commands.size() != 0 || start || expected_results.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_color(input logic idx, input logic [3:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_FOREGROUND)
            fg_color = value;
        else
            bg_color = value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [7:0] printable_char();
        logic [7:0] ch;
        ch = 8'($urandom);
        if (ch == NEWLINE_CODE)
            ch = SPACE_CODE;
        return ch;
    endfunction

    // random traffic: mostly text lines ended by a newline, with reads and the rest mixed in
    task automatic queue_random_phase(input int count);
        int start_size;
        int pick;
        int len;
        int k;
        start_size = pending_commands.size();
        while (pending_commands.size() - start_size < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // short line, now and then one long enough to wrap
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 6);
                for (k = 0; k < len; k++)
                    add_cmd(CMD_PUT, printable_char(), 5'($urandom), 7'($urandom));
                add_cmd(CMD_PUT, NEWLINE_CODE, 5'($urandom), 7'($urandom));
            end
            else if (pick < 62)
            begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    add_cmd(CMD_PUT, NEWLINE_CODE, 5'($urandom), 7'($urandom));
            end
            else if (pick < 84)
            begin
                if ($urandom_range(0, 5) == 0)
                    add_cmd(CMD_READ, 8'($urandom), 5'($urandom), 7'($urandom));
                else
                    add_cmd(CMD_READ, 8'($urandom), 5'($urandom_range(0, ROWS - 1)),
                            7'($urandom_range(0, COLUMNS - 1)));
            end
            else if (pick < 90)
                add_cmd(CMD_PUT, 8'($urandom), 5'($urandom), 7'($urandom));
            else if (pick < 93)
                add_cmd(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
            else if (pick < 96)
                add_cmd(CMD_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
            else
                add_cmd(2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
        end
    endtask

    // stimulus sequence and final verdict
    initial
    begin
        int i;
        int phase;
        int idle_pct [4];
        idle_pct = '{0, 62, 0, 36};

        for (i = 0; i < CELLS; i++)
            shadow_screen[i] = RESET_CELL;
        shadow_row = 0;
        shadow_col = 0;
        fg_color   = FG_RESET;
        bg_color   = BG_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats at reset colors: field extremes, newline, out-of-range reads,
        // unused code, clear
        add_cmd(CMD_PUT, 8'h41, 5'd0, 7'd0);
        add_cmd(CMD_PUT, 8'h00, 5'd31, 7'd127);
        add_cmd(CMD_PUT, 8'hFF, 5'd0, 7'd0);
        add_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
        add_cmd(CMD_READ, 8'hFF, 5'd0, 7'd2);
        add_cmd(CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        add_cmd(CMD_PUT, 8'hF5, 5'd0, 7'd0);
        add_cmd(CMD_PUT, 8'h80, 5'd0, 7'd0);
        add_cmd(CMD_PUT, 8'h7F, 5'd0, 7'd0);
        add_cmd(CMD_READ, 8'h00, 5'd1, 7'd0);
        add_cmd(CMD_READ, 8'h00, 5'd24, 7'd79);
        add_cmd(CMD_READ, 8'h00, 5'd25, 7'd0);
        add_cmd(CMD_READ, 8'h00, 5'd31, 7'd127);
        add_cmd(CMD_READ, 8'h00, 5'd0, 7'd80);
        add_cmd(CMD_READ, 8'h00, 5'd0, 7'd127);
        add_cmd(CMD_UNUSED, 8'hFF, 5'd31, 7'd127);
        add_cmd(CMD_UNUSED, 8'h00, 5'd0, 7'd0);
        add_cmd(CMD_CLEAR, 8'h00, 5'd0, 7'd0);
        add_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
        add_cmd(CMD_READ, 8'h00, 5'd24, 7'd79);
        add_cmd(CMD_PUT, SPACE_CODE, 5'd0, 7'd0);
        add_cmd(CMD_READ, 8'h00, 5'd1, 7'd3);
        add_cmd(CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        wait_quiet();

        // random phases, each under its own colors and sender idling
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_color(REG_FOREGROUND, 4'd0);
                    write_color(REG_BACKGROUND, 4'd15);
                end
                1:
                begin
                    write_color(REG_FOREGROUND, 4'd15);
                    write_color(REG_BACKGROUND, 4'd0);
                end
                2:
                begin
                    write_color(REG_FOREGROUND, 4'($urandom));
                    write_color(REG_BACKGROUND, 4'($urandom));
                end
                default:
                begin
                    write_color(REG_FOREGROUND, 4'd15);
                    write_color(REG_BACKGROUND, 4'd15);
                end
            endcase
            sender_idle_pct = idle_pct[phase];
            queue_random_phase(PHASE_ITEMS);
            wait_quiet();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        mismatch_count += expected_results.size();
        if (mismatch_count == 0)
            $display("text_console_writer regression: pass");
        else
            $display("text_console_writer regression: fail");
        $finish;
    end

endmodule

// ===== text_console_writer.f =====
rtl/tcw_pkg.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
tb/tb_text_console_writer.sv
